// ===== sv/kcvt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcvt_pkg
// Types, codes and helpers shared by the constant-velocity tracker modules.
// ----------------------------------------------------------------------------
package kcvt_pkg;

  typedef struct packed {
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic signed [31:0] meas_z;
  } meas_t;

  typedef struct packed {
    logic signed [31:0] pred_x;
    logic signed [31:0] pred_y;
    logic signed [31:0] pred_z;
  } pred_t;

  typedef logic [3:0] mul_sel_t;
  typedef logic [4:0] wb_op_t;

  // multiplier operand selects
  localparam mul_sel_t MS_NOP    = 4'd0;
  localparam mul_sel_t MS_BB     = 4'd1;
  localparam mul_sel_t MS_DET    = 4'd2;
  localparam mul_sel_t MS_N11    = 4'd3;
  localparam mul_sel_t MS_N12    = 4'd4;
  localparam mul_sel_t MS_N22    = 4'd5;
  localparam mul_sel_t MS_K11EP  = 4'd6;
  localparam mul_sel_t MS_K12EV  = 4'd7;
  localparam mul_sel_t MS_K12EP  = 4'd8;
  localparam mul_sel_t MS_K22EV  = 4'd9;
  localparam mul_sel_t MS_LEAD   = 4'd10;
  localparam mul_sel_t MS_RK11   = 4'd11;
  localparam mul_sel_t MS_RK12   = 4'd12;
  localparam mul_sel_t MS_RK22   = 4'd13;

  // write-back operations, executed in the cycle after issue
  localparam wb_op_t WB_NOP   = 5'd0;
  localparam wb_op_t WB_PRED  = 5'd1;
  localparam wb_op_t WB_SUM   = 5'd2;
  localparam wb_op_t WB_BB    = 5'd3;
  localparam wb_op_t WB_DET   = 5'd4;
  localparam wb_op_t WB_N11   = 5'd5;
  localparam wb_op_t WB_N12   = 5'd6;
  localparam wb_op_t WB_N22   = 5'd7;
  localparam wb_op_t WB_PREP1 = 5'd8;
  localparam wb_op_t WB_PREP2 = 5'd9;
  localparam wb_op_t WB_P1    = 5'd10;
  localparam wb_op_t WB_P2    = 5'd11;
  localparam wb_op_t WB_V1    = 5'd12;
  localparam wb_op_t WB_V2    = 5'd13;
  localparam wb_op_t WB_OUT   = 5'd14;
  localparam wb_op_t WB_CA    = 5'd15;
  localparam wb_op_t WB_CB    = 5'd16;
  localparam wb_op_t WB_CC    = 5'd17;
  localparam wb_op_t WB_KEEP  = 5'd18;

  typedef struct packed {
    mul_sel_t mul;
    wb_op_t   wb;
  } op_t;

  typedef struct packed {
    logic       load_in;
    logic       load_out;
    logic       div_start;
    op_t        op;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic det_pos;
  } sts_t;

  // config register indexes
  localparam logic [1:0] REG_LEAD = 2'd0;
  localparam logic [1:0] REG_QN   = 2'd1;
  localparam logic [1:0] REG_RN   = 2'd2;

  localparam logic [7:0]         LEAD_RESET = 8'd10;
  localparam logic [28:0]        QN_RESET   = 29'd84289;
  localparam logic [28:0]        RN_RESET   = 29'd26843546;
  localparam logic signed [31:0] ONE_Q28    = 32'sh1000_0000;
  localparam logic [4:0]         DIV_LAST   = 5'd30;

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    if (v > 42'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -42'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [31:0] clampv(input logic signed [41:0] v);
    if (v[41]) begin
      return 32'sd0;
    end else begin
      return sat32(v);
    end
  endfunction

  // Q4.28 product back to the other operand's format, nearest, ties up
  function automatic logic signed [35:0] rnd_q28(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd134217728;
    return s[63:28];
  endfunction

endpackage

// ===== sv/kcvt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcvt_div
// Three-lane restoring divider, shared denominator, Q4.28 quotient.
// ----------------------------------------------------------------------------
module kcvt_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic signed [63:0] den,
  input  logic [2:0][63:0]  num,
  output logic              done,
  output logic [2:0][31:0]  quo
);
  import kcvt_pkg::*;

  logic        busy;
  logic [4:0]  cnt;
  logic [65:0] rem    [3];
  logic [66:0] dd     [3];
  logic [30:0] q      [3];
  logic        neg    [3];
  logic        sat    [3];
  logic [66:0] rem2   [3];
  logic        ge     [3];
  logic [30:0] q_next [3];
  logic [63:0] mag    [3];
  logic [31:0] mag_k  [3];
  logic [31:0] fin    [3];
  logic        den_pos;

  assign den_pos = !den[63] && (den != 64'sd0);

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag[l]    = num[l][63] ? (~num[l] + 64'd1) : num[l];
      rem2[l]   = {rem[l], 1'b0};
      ge[l]     = rem2[l] >= dd[l];
      q_next[l] = {q[l][29:0], ge[l]};
      mag_k[l]  = sat[l] ? 32'h7fff_ffff : {1'b0, q_next[l]};
      fin[l]    = neg[l] ? (~mag_k[l] + 32'd1) : mag_k[l];
    end
  end

  // quotient of |num| * 2^28 / den, taken as |num| * 2^31 / (8 * den)
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (den_pos) begin
          busy <= 1'b1;
          cnt  <= 5'd0;
          for (int l = 0; l < 3; l++) begin
            rem[l] <= {2'b0, mag[l]};
            dd[l]  <= {den, 3'b0};
            q[l]   <= '0;
            neg[l] <= num[l][63];
            sat[l] <= {3'b0, mag[l]} >= {den, 3'b0};
          end
        end else begin
          for (int l = 0; l < 3; l++) quo[l] <= '0;
          done <= 1'b1;
        end
      end else if (busy) begin
        for (int l = 0; l < 3; l++) begin
          rem[l] <= ge[l] ? 66'(rem2[l] - dd[l]) : rem2[l][65:0];
          q[l]   <= q_next[l];
        end
        cnt <= cnt + 5'd1;
        if (cnt == DIV_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
          for (int l = 0; l < 3; l++) quo[l] <= fin[l];
        end
      end
    end
  end

endmodule

// ===== sv/kcvt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcvt_dp
// Tracker datapath: config and filter state, one shared multiplier with a
// registered write-back stage, gain divider, result staging and output word.
// ----------------------------------------------------------------------------
module kcvt_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  input  kcvt_pkg::meas_t  meas,
  output kcvt_pkg::pred_t  pred,
  input  kcvt_pkg::cmd_t   cmd,
  output kcvt_pkg::sts_t   sts
);
  import kcvt_pkg::*;

  logic [7:0]  lead;
  logic [28:0] qn;
  logic [28:0] rn;

  logic signed [31:0] prev [3];
  logic signed [31:0] pos  [3];
  logic signed [31:0] vel  [3];
  logic signed [31:0] zin  [3];
  logic signed [31:0] res  [3];
  logic signed [31:0] ca, cb, cc;

  logic signed [31:0] ap, bp, cp;
  logic signed [33:0] s11, s22;
  logic signed [63:0] bb, det, n11, n12, n22;
  logic signed [31:0] pp, ep, ev, pn, vn;
  logic signed [41:0] accp, accv;

  logic signed [33:0] ma, mb;
  logic signed [67:0] product;
  logic signed [63:0] prod_q;
  wb_op_t             wb_q;
  logic [1:0]         ax_q;

  logic signed [41:0] a_sum, q42;
  logic signed [33:0] r34;
  logic signed [35:0] rnd_v;
  logic [2:0][31:0]   quo;
  logic signed [31:0] k11, k12, k22;
  logic               div_done;

  kcvt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .den   (det),
    .num   ({n22, n12, n11}),
    .done  (div_done),
    .quo   (quo)
  );

  assign k11 = quo[0];
  assign k12 = quo[1];
  assign k22 = quo[2];

  assign sts.div_done = div_done;
  assign sts.det_pos  = !det[63] && (det != 64'sd0);

  assign q42   = $signed({13'b0, qn});
  assign r34   = $signed({5'b0, rn});
  assign a_sum = 42'(ca) + (42'(cb) <<< 1) + 42'(cc) + q42;
  assign rnd_v = rnd_q28(prod_q);

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op.mul)
      MS_NOP:   begin ma = '0;       mb = '0;       end
      MS_BB:    begin ma = 34'(bp);  mb = 34'(bp);  end
      MS_DET:   begin ma = s11;      mb = s22;      end
      MS_N11:   begin ma = 34'(ap);  mb = s22;      end
      MS_N12:   begin ma = 34'(bp);  mb = r34;      end
      MS_N22:   begin ma = 34'(cp);  mb = s11;      end
      MS_K11EP: begin ma = 34'(k11); mb = 34'(ep);  end
      MS_K12EV: begin ma = 34'(k12); mb = 34'(ev);  end
      MS_K12EP: begin ma = 34'(k12); mb = 34'(ep);  end
      MS_K22EV: begin ma = 34'(k22); mb = 34'(ev);  end
      MS_LEAD:  begin ma = $signed({26'b0, lead}); mb = 34'(vn); end
      MS_RK11:  begin ma = r34;      mb = 34'(k11); end
      MS_RK12:  begin ma = r34;      mb = 34'(k12); end
      MS_RK22:  begin ma = r34;      mb = 34'(k22); end
      default:  begin ma = '0;       mb = '0;       end
    endcase
  end

  assign product = ma * mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_q <= WB_NOP;
    end else begin
      wb_q <= cmd.op.wb;
    end
    ax_q   <= cmd.axis;
    prod_q <= product[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead <= LEAD_RESET;
      qn   <= QN_RESET;
      rn   <= RN_RESET;
      for (int i = 0; i < 3; i++) begin
        prev[i] <= '0;
        pos[i]  <= '0;
        vel[i]  <= '0;
      end
      ca <= ONE_Q28;
      cb <= '0;
      cc <= ONE_Q28;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_LEAD: lead <= cfg_data[7:0];
          REG_QN:   qn   <= cfg_data[28:0];
          REG_RN:   rn   <= cfg_data[28:0];
          default:  ;
        endcase
      end
      if (cmd.load_in) begin
        zin[0] <= meas.meas_x;
        zin[1] <= meas.meas_y;
        zin[2] <= meas.meas_z;
      end
      if (cmd.load_out) begin
        pred.pred_x <= res[0];
        pred.pred_y <= res[1];
        pred.pred_z <= res[2];
      end
      unique case (wb_q)
        WB_NOP:   ;
        WB_PRED: begin
          ap <= clampv(a_sum);
          bp <= sat32(42'(cb) + 42'(cc));
          cp <= clampv(42'(cc) + q42);
        end
        WB_SUM: begin
          s11 <= 34'(ap) + r34;
          s22 <= 34'(cp) + r34;
        end
        WB_BB:    bb  <= prod_q;
        WB_DET:   det <= prod_q - bb;
        WB_N11:   n11 <= prod_q - bb;
        WB_N12:   n12 <= prod_q;
        WB_N22:   n22 <= prod_q - bb;
        WB_PREP1: pp  <= sat32(42'(pos[ax_q]) + 42'(vel[ax_q]));
        WB_PREP2: begin
          ep <= sat32(42'(zin[ax_q]) - 42'(pp));
          ev <= sat32(42'(zin[ax_q]) - 42'(prev[ax_q]) - 42'(vel[ax_q]));
        end
        WB_P1:    accp <= 42'(pp) + 42'(rnd_v);
        WB_P2:    pn   <= sat32(accp + 42'(rnd_v));
        WB_V1:    accv <= 42'(vel[ax_q]) + 42'(rnd_v);
        WB_V2:    vn   <= sat32(accv + 42'(rnd_v));
        WB_OUT: begin
          res[ax_q]  <= sat32(42'(pn) + $signed(prod_q[41:0]));
          prev[ax_q] <= zin[ax_q];
          pos[ax_q]  <= pn;
          vel[ax_q]  <= vn;
        end
        WB_CA:    ca <= sat32(42'(rnd_v));
        WB_CB:    cb <= sat32(42'(rnd_v));
        WB_CC:    cc <= sat32(42'(rnd_v));
        WB_KEEP: begin
          ca <= ap;
          cb <= bp;
          cc <= cp;
        end
        default:  ;
      endcase
    end
  end

endmodule

// ===== sv/kcvt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcvt_ctrl
// Sequencer: steps the datapath through covariance predict, gain divide,
// per-axis correction and covariance update, then hands off the result word.
// ----------------------------------------------------------------------------
module kcvt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           meas_valid,
  output logic           meas_stall,
  output logic           pred_valid,
  input  logic           pred_stall,
  input  kcvt_pkg::sts_t sts,
  output kcvt_pkg::cmd_t cmd
);
  import kcvt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FRONT = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_AXES  = 3'd3;
  localparam logic [2:0] S_COV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [3:0] FRONT_LAST = 4'd7;
  localparam logic [3:0] AXIS_LAST  = 4'd8;
  localparam logic [3:0] COV_LAST   = 4'd3;
  localparam logic [1:0] AXES_LAST  = 2'd2;

  logic [2:0] state, state_next;
  logic [3:0] step, step_next;
  logic [1:0] axis, axis_next;

  function automatic op_t front_op(input logic [3:0] s);
    unique case (s)
      4'd0:    return '{mul: MS_NOP, wb: WB_PRED};
      4'd1:    return '{mul: MS_NOP, wb: WB_SUM};
      4'd2:    return '{mul: MS_BB,  wb: WB_BB};
      4'd3:    return '{mul: MS_DET, wb: WB_DET};
      4'd4:    return '{mul: MS_N11, wb: WB_N11};
      4'd5:    return '{mul: MS_N12, wb: WB_N12};
      4'd6:    return '{mul: MS_N22, wb: WB_N22};
      default: return '{mul: MS_NOP, wb: WB_NOP};
    endcase
  endfunction

  // bubbles wait for ep and vn to land before they feed the multiplier
  function automatic op_t axis_op(input logic [3:0] s);
    unique case (s)
      4'd0:    return '{mul: MS_NOP,   wb: WB_PREP1};
      4'd1:    return '{mul: MS_NOP,   wb: WB_PREP2};
      4'd3:    return '{mul: MS_K11EP, wb: WB_P1};
      4'd4:    return '{mul: MS_K12EV, wb: WB_P2};
      4'd5:    return '{mul: MS_K12EP, wb: WB_V1};
      4'd6:    return '{mul: MS_K22EV, wb: WB_V2};
      4'd8:    return '{mul: MS_LEAD,  wb: WB_OUT};
      default: return '{mul: MS_NOP,   wb: WB_NOP};
    endcase
  endfunction

  function automatic op_t cov_op(input logic [3:0] s, input logic ok);
    unique case (s)
      4'd0:    return ok ? op_t'{mul: MS_RK11, wb: WB_CA} : op_t'{mul: MS_NOP, wb: WB_KEEP};
      4'd1:    return ok ? op_t'{mul: MS_RK12, wb: WB_CB} : op_t'{mul: MS_NOP, wb: WB_NOP};
      4'd2:    return ok ? op_t'{mul: MS_RK22, wb: WB_CC} : op_t'{mul: MS_NOP, wb: WB_NOP};
      default: return '{mul: MS_NOP, wb: WB_NOP};
    endcase
  endfunction

  assign meas_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    step_next  = step;
    axis_next  = axis;
    unique case (state)
      S_IDLE: begin
        if (meas_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_FRONT;
          step_next   = '0;
        end
      end
      S_FRONT: begin
        cmd.op    = front_op(step);
        step_next = step + 4'd1;
        if (step == FRONT_LAST) begin
          state_next = S_DIV;
          step_next  = '0;
        end
      end
      S_DIV: begin
        if (step == 4'd0) begin
          cmd.div_start = 1'b1;
          step_next     = 4'd1;
        end else if (sts.div_done) begin
          state_next = S_AXES;
          step_next  = '0;
          axis_next  = '0;
        end
      end
      S_AXES: begin
        cmd.op    = axis_op(step);
        cmd.axis  = axis;
        step_next = step + 4'd1;
        if (step == AXIS_LAST) begin
          step_next = '0;
          if (axis == AXES_LAST) begin
            state_next = S_COV;
          end else begin
            axis_next = axis + 2'd1;
          end
        end
      end
      S_COV: begin
        cmd.op    = cov_op(step, sts.det_pos);
        step_next = step + 4'd1;
        if (step == COV_LAST) begin
          state_next = S_DONE;
          step_next  = '0;
        end
      end
      S_DONE: begin
        if (!pred_valid || !pred_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= '0;
      axis       <= '0;
      pred_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      axis  <= axis_next;
      if (cmd.load_out) begin
        pred_valid <= 1'b1;
      end else if (!pred_stall) begin
        pred_valid <= 1'b0;
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (meas_valid && !meas_stall) |=> (state == S_FRONT && step == 4'd0))
    else $error("accepted word did not start the sequence");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide phase");

  a_handoff: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!pred_valid || !pred_stall)) |=> (pred_valid && state == S_IDLE))
    else $error("result word not handed to output register");

endmodule

// ===== sv/kalman_constant_velocity_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_constant_velocity_tracker
// 3-D constant-velocity Kalman tracker, Q16.16 positions, Q4.28 covariance.
// ----------------------------------------------------------------------------
// Usage:
//   meas channel: one word (x, y, z) per measurement, valid/stall.
//   pred channel: one word per measurement, position plus lead_ticks times
//   velocity, saturated; valid/stall.
//   cfg channel: valid/ready write of lead_ticks (0), process_noise (1),
//   measurement_noise (2); ready is always high. Write only while idle.
// Timing: one word in flight. From accept to pred_valid the sequencer runs
//   8 covariance/multiply steps, the gain divide phase (start, 31 three-lane
//   divider iterations, finish; only start and finish when the innovation
//   determinant is not positive), the per-axis steps on the shared
//   multiplier, the covariance update and the handoff.
//   The next word is accepted the cycle after the result moves into the
//   output register; a new word is not taken while one is in flight.
// Reset (synchronous, rst high): filter state and covariance return to their
//   initial values and config registers to defaults; pred_valid drops.
// Stall: a stalled pred word holds; a finished word waits in the sequencer
//   until the output register frees, and meas stays stalled meanwhile.
// ----------------------------------------------------------------------------
module kalman_constant_velocity_tracker (
  input  logic            clk,
  input  logic            rst,
  input  logic            meas_valid,
  output logic            meas_stall,
  input  kcvt_pkg::meas_t meas,
  output logic            pred_valid,
  input  logic            pred_stall,
  output kcvt_pkg::pred_t pred,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data
);
  import kcvt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  kcvt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .meas_valid (meas_valid),
    .meas_stall (meas_stall),
    .pred_valid (pred_valid),
    .pred_stall (pred_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  kcvt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .meas      (meas),
    .pred      (pred),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
